>>> rtl/core/boundary_tag_heap_allocator_macros.svh
// Assertion macros used by the checker module of the heap allocator.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("heap allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BTH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("heap allocator check failed");

`endif

>>> rtl/core/bth_pkg.sv
package bth_pkg;

    // Request kinds carried in tuser.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Heap layout constants, as 17-bit byte quantities.
    localparam logic [16:0] FIRST_HDR   = 17'd4;
    localparam logic [16:0] MIN_PAYLOAD = 17'd8;
    localparam logic [16:0] SPLIT_MIN   = 17'd16;
    localparam logic [16:0] TINY_HEAP   = 17'd24;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_INIT, S_INIT2, S_IDLE,
        S_A_TOP, S_A_CHK, S_A_NXT, S_A_DEC, S_A_SP1, S_A_SP2, S_A_RES,
        S_LK_N, S_LK_P, S_LK_C,
        S_W_TOP, S_W_EV, S_W_ADV,
        S_F_R1, S_F_R2, S_F_RT, S_F_RU, S_F_RM,
        S_F_L, S_F_LT, S_F_LX, S_F_LU, S_F_LM, S_F_FIN, S_F_OK,
        S_WR, S_DONE
    } t_state;

    // Write sequences run by the write state.
    typedef enum logic [2:0] {
        P_INIT, P_SPLIT, P_UNLINK, P_WHOLE, P_FREE
    } t_prog;

endpackage

>>> rtl/core/bth_ram.sv
module bth_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: a write or a registered read each cycle while enabled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/boundary_tag_heap_allocator.sv
// Allocate passes over free-list nodes in turn; free and check pass over block headers in turn.
// Throughput: one item at a time; the shared offset adder and the single-port heap RAM
// banks serialize every step, so the rate is set by the list or header walk length.
// Reset and each heap size write run an init that writes the first block's tags (none
// when the heap is too small for a block); heap RAM contents are not cleared.
module boundary_tag_heap_allocator #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Heap size register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,     // heap_bytes
    // Request items.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,      // [15:0] req_size, [31:16] addr
    input  logic [1:0]  i_s_tuser,      // [1:0] op
    // Result items.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata       // [15:0] result_addr, [16] status, [23:17] zero
);

    import bth_pkg::*;

    localparam int BANK_DEPTH = MEM_BYTES / 4;
    localparam int BAW = $clog2(BANK_DEPTH);
    localparam logic [16:0] MEM_LIM = 17'(MEM_BYTES);
    localparam logic [16:0] C_M4  = 17'h1FFFC;
    localparam logic [16:0] C_M7  = 17'h1FFF9;
    localparam logic [16:0] C_M16 = 17'h1FFF0;

    function automatic logic [31:0] neg_tag(input logic [15:0] v);
        return {16'hFFFF, 16'(16'd0 - v)};
    endfunction

    function automatic logic [31:0] pos_val(input logic [15:0] v);
        return {16'h0000, v};
    endfunction

    t_state r_state, n_state, r_ret;
    t_prog  r_prog;
    logic [2:0]  r_k;
    logic [1:0]  r_op;
    logic [15:0] r_addr;
    logic [16:0] r_s, r_h, r_x, r_nb, r_b, r_end, r_used;
    logic [15:0] r_hs, r_ns, r_n, r_p, r_m, r_t, r_head, r_res;
    logic        r_st, r_par, r_ovalid;
    logic [16:0] r_odata;

    // Shared offset and size adder.
    logic [16:0] u_a, u_b, u_c, u_sum;
    logic        u_inv;
    assign u_sum = u_a + (u_inv ? ~u_b : u_b) + u_c;

    // Heap access request, 32 bits at a byte offset given by the adder.
    logic        m_en, m_we;
    logic [31:0] m_wdata, m_q;
    logic        w_last, w_hset;
    logic [15:0] w_hval;

    logic        cfg_acc, s_acc, idle, fit, q_alloc, q_free_nz, can_out;
    logic [15:0] q_size;
    logic [16:0] cfg_used, s_even;

    assign idle        = (r_state == S_IDLE);
    assign o_cfg_ready = idle;
    assign o_s_tready  = idle & ~i_cfg_valid;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign s_acc       = i_s_tvalid & o_s_tready;
    assign can_out     = ~r_ovalid | i_m_tready;

    assign cfg_used  = ((i_cfg_data < MEM_LIM) ? i_cfg_data : MEM_LIM) & 17'h1FFFE;
    assign s_even    = (u_sum < MIN_PAYLOAD) ? MIN_PAYLOAD : u_sum;
    assign q_alloc   = m_q[31];
    assign q_size    = q_alloc ? 16'(16'd0 - m_q[15:0]) : m_q[15:0];
    assign q_free_nz = ~m_q[31] & (m_q != 32'd0);
    assign fit       = ({1'b0, m_q[15:0]} >= r_s);

    // Adder operands, memory requests and write sequence steps.
    always_comb begin
        u_a = 17'd0; u_b = 17'd0; u_c = 17'd0; u_inv = 1'b0;
        m_en = 1'b0; m_we = 1'b0; m_wdata = 32'd0;
        w_last = 1'b0; w_hset = 1'b0; w_hval = 16'd0;
        case (r_state)
            S_INIT:  begin u_a = r_used; u_c = C_M4; end
            S_INIT2: begin u_a = r_used; u_c = C_M16; end
            S_IDLE:  begin u_a = {1'b0, i_s_tdata[15:0]}; u_c = {16'd0, i_s_tdata[0]}; end
            S_A_TOP: begin u_a = r_h; m_en = (r_h != 17'd0); end
            S_A_CHK: begin u_a = r_h; u_c = 17'd4; m_en = ~fit; end
            S_LK_N:  begin u_a = r_x; u_c = 17'd4; m_en = 1'b1; end
            S_LK_P:  begin u_a = r_x; u_c = 17'd8; m_en = 1'b1; end
            S_A_DEC: begin u_a = {1'b0, r_hs}; u_b = r_s; u_inv = 1'b1; u_c = 17'd1; end
            S_A_SP1: begin u_a = r_h; u_b = r_s; u_c = 17'd8; end
            S_A_SP2: begin u_a = {1'b0, r_hs}; u_b = r_s; u_inv = 1'b1; u_c = C_M7; end
            S_A_RES: begin u_a = r_h; u_c = 17'd4; end
            S_W_TOP: begin u_a = r_h; m_en = (r_h < r_end); end
            S_W_EV:  begin u_a = r_h; u_c = 17'd4; end
            S_W_ADV: begin u_a = r_h; u_b = {1'b0, r_m}; u_c = 17'd8; end
            S_F_R1:  begin u_a = r_h; u_b = {1'b0, r_m}; u_c = 17'd8; end
            S_F_R2:  begin u_a = r_x; m_en = (r_x < r_end); end
            S_F_RM:  begin u_a = {1'b0, r_m}; u_b = {1'b0, r_t}; u_c = 17'd8; end
            S_F_L:   begin u_a = r_h; u_c = C_M4; m_en = (r_h > FIRST_HDR); end
            S_F_LX:  begin u_a = r_h; u_b = {1'b0, r_t}; u_inv = 1'b1; u_c = C_M7; end
            S_F_LM:  begin u_a = {1'b0, r_m}; u_b = {1'b0, r_t}; u_c = 17'd8; end
            S_WR: begin
                m_en = 1'b1; m_we = 1'b1;
                case (r_prog)
                    P_INIT: begin
                        w_last = (r_k == 3'd3);
                        case (r_k)
                            3'd0: begin u_c = 17'd4; m_wdata = pos_val(r_m); end
                            3'd1: begin
                                u_a = {1'b0, r_m}; u_c = 17'd8; m_wdata = pos_val(r_m);
                            end
                            3'd2: u_c = 17'd8;
                            default: u_c = 17'd12;
                        endcase
                    end
                    P_SPLIT: begin
                        w_last = (r_k == 3'd7);
                        case (r_k)
                            3'd0: begin u_a = r_nb; m_wdata = pos_val(r_ns); end
                            3'd1: begin
                                u_a = r_nb; u_b = {1'b0, r_ns}; u_c = 17'd4;
                                m_wdata = pos_val(r_ns);
                            end
                            3'd2: begin u_a = r_nb; u_c = 17'd4; m_wdata = pos_val(r_n); end
                            3'd3: begin u_a = r_nb; u_c = 17'd8; m_wdata = pos_val(r_p); end
                            3'd4: begin
                                u_a = {1'b0, r_p}; u_c = 17'd4; m_wdata = pos_val(r_nb[15:0]);
                                m_en = (r_p != 16'd0); m_we = m_en;
                                w_hset = (r_p == 16'd0); w_hval = r_nb[15:0];
                            end
                            3'd5: begin
                                u_a = {1'b0, r_n}; u_c = 17'd8; m_wdata = pos_val(r_nb[15:0]);
                                m_en = (r_n != 16'd0); m_we = m_en;
                            end
                            3'd6: begin u_a = r_h; m_wdata = neg_tag(r_s[15:0]); end
                            default: begin
                                u_a = r_h; u_b = r_s; u_c = 17'd4;
                                m_wdata = neg_tag(r_s[15:0]);
                            end
                        endcase
                    end
                    P_UNLINK, P_WHOLE: begin
                        w_last = (r_prog == P_UNLINK) ? (r_k == 3'd1) : (r_k == 3'd3);
                        case (r_k)
                            3'd0: begin
                                u_a = {1'b0, r_p}; u_c = 17'd4; m_wdata = pos_val(r_n);
                                m_en = (r_p != 16'd0); m_we = m_en;
                                w_hset = (r_p == 16'd0); w_hval = r_n;
                            end
                            3'd1: begin
                                u_a = {1'b0, r_n}; u_c = 17'd8; m_wdata = pos_val(r_p);
                                m_en = (r_n != 16'd0); m_we = m_en;
                            end
                            3'd2: begin u_a = r_h; m_wdata = neg_tag(r_hs); end
                            default: begin
                                u_a = r_h; u_b = {1'b0, r_hs}; u_c = 17'd4;
                                m_wdata = neg_tag(r_hs);
                            end
                        endcase
                    end
                    default: begin
                        w_last = (r_k == 3'd4);
                        case (r_k)
                            3'd0: begin u_a = r_b; m_wdata = pos_val(r_m); end
                            3'd1: begin
                                u_a = r_b; u_b = {1'b0, r_m}; u_c = 17'd4;
                                m_wdata = pos_val(r_m);
                            end
                            3'd2: begin u_a = r_b; u_c = 17'd4; m_wdata = pos_val(r_head); end
                            3'd3: begin u_a = r_b; u_c = 17'd8; end
                            default: begin
                                u_a = {1'b0, r_head}; u_c = 17'd8;
                                m_wdata = pos_val(r_b[15:0]);
                                m_en = (r_head != 16'd0); m_we = m_en;
                                w_hset = 1'b1; w_hval = r_b[15:0];
                            end
                        endcase
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:  n_state = (r_used < TINY_HEAP) ? S_IDLE : S_INIT2;
            S_INIT2: n_state = S_WR;
            S_IDLE: begin
                if (cfg_acc) begin
                    n_state = S_INIT;
                end else if (s_acc) begin
                    if (i_s_tuser == OP_ALLOC) begin
                        n_state = S_A_TOP;
                    end else if (i_s_tuser == OP_FREE || i_s_tuser == OP_CHECK) begin
                        n_state = S_W_TOP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_A_TOP: n_state = (r_h == 17'd0) ? S_DONE : S_A_CHK;
            S_A_CHK: n_state = fit ? S_LK_N : S_A_NXT;
            S_A_NXT: n_state = S_A_TOP;
            S_LK_N:  n_state = S_LK_P;
            S_LK_P:  n_state = S_LK_C;
            S_LK_C:  n_state = r_ret;
            S_A_DEC: n_state = (u_sum >= SPLIT_MIN) ? S_A_SP1 : S_WR;
            S_A_SP1: n_state = S_A_SP2;
            S_A_SP2: n_state = S_WR;
            S_A_RES: n_state = S_DONE;
            S_W_TOP: n_state = (r_h < r_end) ? S_W_EV : S_DONE;
            S_W_EV: begin
                if (u_sum == {1'b0, r_addr}) begin
                    n_state = (q_alloc && r_op == OP_FREE) ? S_F_R1 : S_DONE;
                end else begin
                    n_state = S_W_ADV;
                end
            end
            S_W_ADV: n_state = S_W_TOP;
            S_F_R1:  n_state = S_F_R2;
            S_F_R2:  n_state = (r_x < r_end) ? S_F_RT : S_F_L;
            S_F_RT:  n_state = q_free_nz ? S_LK_N : S_F_L;
            S_F_RU:  n_state = S_WR;
            S_F_RM:  n_state = S_F_L;
            S_F_L:   n_state = (r_h > FIRST_HDR) ? S_F_LT : S_F_FIN;
            S_F_LT:  n_state = q_free_nz ? S_F_LX : S_F_FIN;
            S_F_LX:  n_state = S_LK_N;
            S_F_LU:  n_state = S_WR;
            S_F_LM:  n_state = S_F_FIN;
            S_F_FIN: n_state = S_WR;
            S_F_OK:  n_state = S_DONE;
            S_WR:    n_state = w_last ? r_ret : S_WR;
            S_DONE:  n_state = can_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_used   <= MEM_LIM & 17'h1FFFE;
            r_ovalid <= 1'b0;
            r_head   <= 16'd0;
            r_end    <= FIRST_HDR;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && can_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_acc) begin
                r_used <= cfg_used;
            end
            if (r_state == S_INIT) begin
                if (r_used < TINY_HEAP) begin
                    r_head <= 16'd0;
                    r_end  <= FIRST_HDR;
                end else begin
                    r_head <= FIRST_HDR[15:0];
                    r_end  <= u_sum;
                end
            end else if (r_state == S_WR && w_hset) begin
                r_head <= w_hval;
            end
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && can_out) begin
            r_odata <= {r_st, r_res};
        end
        if (m_en && !m_we) begin
            r_par <= u_sum[1];
        end
        case (r_state)
            S_INIT2: begin
                r_m    <= u_sum[15:0];
                r_prog <= P_INIT;
                r_k    <= 3'd0;
                r_ret  <= S_IDLE;
            end
            S_IDLE: begin
                r_op   <= i_s_tuser;
                r_addr <= i_s_tdata[31:16];
                r_s    <= s_even;
                r_h    <= (i_s_tuser == OP_ALLOC) ? {1'b0, r_head} : FIRST_HDR;
                r_res  <= 16'd0;
                r_st   <= 1'b1;
            end
            S_A_CHK: begin
                if (fit) begin
                    r_x   <= r_h;
                    r_hs  <= m_q[15:0];
                    r_ret <= S_A_DEC;
                end
            end
            S_A_NXT: r_h <= {1'b0, m_q[15:0]};
            S_LK_P:  r_n <= m_q[15:0];
            S_LK_C:  r_p <= m_q[15:0];
            S_A_DEC: begin
                r_prog <= P_WHOLE;
                r_k    <= 3'd0;
                r_ret  <= S_A_RES;
            end
            S_A_SP1: r_nb <= u_sum;
            S_A_SP2: begin
                r_ns   <= u_sum[15:0];
                r_prog <= P_SPLIT;
                r_k    <= 3'd0;
                r_ret  <= S_A_RES;
            end
            S_A_RES: begin
                r_res <= u_sum[15:0];
                r_st  <= 1'b0;
            end
            S_W_EV: begin
                r_m <= q_size;
                r_b <= r_h;
                if (u_sum == {1'b0, r_addr} && q_alloc && r_op == OP_CHECK) begin
                    r_st <= 1'b0;
                end
            end
            S_W_ADV: r_h <= u_sum;
            S_F_R1:  r_x <= u_sum;
            S_F_RT: begin
                r_t   <= m_q[15:0];
                r_ret <= S_F_RU;
            end
            S_F_RU: begin
                r_prog <= P_UNLINK;
                r_k    <= 3'd0;
                r_ret  <= S_F_RM;
            end
            S_F_RM:  r_m <= u_sum[15:0];
            S_F_LT:  r_t <= m_q[15:0];
            S_F_LX: begin
                r_x   <= u_sum;
                r_ret <= S_F_LU;
            end
            S_F_LU: begin
                r_b    <= r_x;
                r_prog <= P_UNLINK;
                r_k    <= 3'd0;
                r_ret  <= S_F_LM;
            end
            S_F_LM:  r_m <= u_sum[15:0];
            S_F_FIN: begin
                r_prog <= P_FREE;
                r_k    <= 3'd0;
                r_ret  <= S_F_OK;
            end
            S_F_OK:  r_st <= 1'b0;
            S_WR:    r_k <= r_k + 3'd1;
            default: ;
        endcase
    end

    // Two 16-bit banks: even heap words in bank A, odd words in bank B.
    logic [BAW-1:0] ba, ba1, a_addr;
    logic [15:0]    a_wd, b_wd, a_q, b_q;
    logic           par;

    assign par    = u_sum[1];
    assign ba     = u_sum[BAW+1:2];
    assign ba1    = ba + {{(BAW-1){1'b0}}, 1'b1};
    assign a_addr = par ? ba1 : ba;
    assign a_wd   = par ? m_wdata[31:16] : m_wdata[15:0];
    assign b_wd   = par ? m_wdata[15:0] : m_wdata[31:16];
    assign m_q    = r_par ? {a_q, b_q} : {b_q, a_q};

    bth_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_bank_a (
        .i_clk   (i_clk),
        .i_en    (m_en),
        .i_we    (m_we),
        .i_addr  (a_addr),
        .i_wdata (a_wd),
        .o_rdata (a_q)
    );

    bth_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_bank_b (
        .i_clk   (i_clk),
        .i_en    (m_en),
        .i_we    (m_we),
        .i_addr  (ba),
        .i_wdata (b_wd),
        .o_rdata (b_q)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_odata};

endmodule

>>> rtl/core/bth_chk.sv
`include "boundary_tag_heap_allocator_macros.svh"

module bth_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // A stalled result item holds its value.
    `BTH_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // An accepted request keeps the block busy in the next cycle.
    `BTH_ASSERT_NXT(a_busy_after_req, i_s_tvalid && o_s_tready, !o_s_tready && !o_cfg_ready)

    // A heap size write starts the init sequence, so no request is taken next.
    `BTH_ASSERT_NXT(a_busy_after_cfg, i_cfg_valid && o_cfg_ready, !o_s_tready)

    // A failure never grants an address.
    `BTH_ASSERT_IMP(a_fail_no_addr, o_m_tvalid && o_m_tdata[16], o_m_tdata[15:0] == 16'd0)

endmodule

bind boundary_tag_heap_allocator bth_chk u_bth_chk (.*);

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bth_pkg::*;

    // The unused request kind; it answers with a failure and changes nothing.
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int unsigned WALK_LIMIT = 65536 / 16 + 2;
    localparam int unsigned STORE_MASK = 32767;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] req_size;
        logic [15:0] addr;
    } heap_req_t;

    typedef struct packed {
        logic [15:0] result_addr;
        logic        status;
    } heap_resp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;

    boundary_tag_heap_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    heap_req_t   request_q[$];
    heap_resp_t  response_q[$];
    int unsigned err_count = 0;
    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 51;
    int unsigned hold_cycles = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    logic        req_taken = 1'b0;

    // Shadow copy of the heap and its bookkeeping.
    logic [15:0] shadow_heap [32768];
    int unsigned shadow_head;
    int unsigned shadow_end;
    int unsigned live_addrs[$];

    function automatic int unsigned rd32(int unsigned off);
        int unsigned w;
        w = (off >> 1) & STORE_MASK;
        return {shadow_heap[(w + 1) & STORE_MASK], shadow_heap[w]};
    endfunction

    function automatic void wr32(int unsigned off, int unsigned v);
        int unsigned w;
        w = (off >> 1) & STORE_MASK;
        shadow_heap[w] = v[15:0];
        shadow_heap[(w + 1) & STORE_MASK] = v[31:16];
    endfunction

    function automatic int unsigned tag_bytes(int unsigned t);
        return t[31] ? (0 - t) : t;
    endfunction

    function automatic void put_tags(int unsigned h, int unsigned tag, int unsigned sz);
        wr32(h, tag);
        wr32(h + 4 + sz, tag);
    endfunction

    function automatic void detach(int unsigned x);
        int unsigned n, p;
        n = rd32(x + 4);
        p = rd32(x + 8);
        if (p != 0) wr32(p + 4, n);
        else shadow_head = n;
        if (n != 0) wr32(n + 8, p);
    endfunction

    function automatic void heap_reinit(logic [16:0] bytes);
        int unsigned used;
        used = (bytes > 65536) ? 65536 : bytes;
        used = used & ~1;
        foreach (shadow_heap[i]) shadow_heap[i] = '0;
        live_addrs.delete();
        if (used < 24) begin
            shadow_end = 4;
            shadow_head = 0;
        end else begin
            shadow_end = used - 4;
            put_tags(4, used - 16, used - 16);
            wr32(8, 0);
            wr32(12, 0);
            shadow_head = 4;
        end
    endfunction

    // Header offset of the block whose payload sits at addr, or 0.
    function automatic int unsigned header_of(int unsigned addr);
        int unsigned h;
        h = 4;
        for (int i = 0; i < WALK_LIMIT && h < shadow_end; i++) begin
            if (h + 4 == addr) return h;
            h += 8 + tag_bytes(rd32(h));
        end
        return 0;
    endfunction

    function automatic bit block_in_use(int unsigned addr);
        int unsigned h;
        h = header_of(addr);
        return h != 0 && rd32(h) >> 31 != 0;
    endfunction

    function automatic int unsigned first_fit_alloc(int unsigned req);
        int unsigned s, h, hs, nb, ns, n, p;
        int i;
        s = (req + 1) & ~1;
        h = shadow_head;
        hs = 0;
        if (s < 8) s = 8;
        for (i = 0; i < WALK_LIMIT && h != 0; i++) begin
            hs = rd32(h);
            if (hs >= s) break;
            h = rd32(h + 4);
        end
        if (h == 0 || i >= WALK_LIMIT) return 0;
        if (hs - s >= 16) begin
            // Split: the remainder takes over the list position of the block.
            nb = h + 8 + s;
            ns = hs - s - 8;
            n = rd32(h + 4);
            p = rd32(h + 8);
            put_tags(nb, ns, ns);
            wr32(nb + 4, n);
            wr32(nb + 8, p);
            if (p != 0) wr32(p + 4, nb);
            else shadow_head = nb;
            if (n != 0) wr32(n + 8, nb);
            put_tags(h, 0 - s, s);
        end else begin
            detach(h);
            put_tags(h, 0 - hs, hs);
        end
        return h + 4;
    endfunction

    function automatic bit release_block(int unsigned addr);
        int unsigned h, b, m, r, rt, lt, l;
        if (!block_in_use(addr)) return 1'b0;
        h = addr - 4;
        m = tag_bytes(rd32(h));
        b = h;
        r = h + 8 + m;
        // Merge with a free right neighbor, then with a free left neighbor.
        if (r < shadow_end) begin
            rt = rd32(r);
            if (!rt[31] && rt != 0) begin
                detach(r);
                m += 8 + rt;
            end
        end
        if (h > 4) begin
            lt = rd32(h - 4);
            if (!lt[31] && lt != 0) begin
                l = h - 8 - lt;
                detach(l);
                b = l;
                m += 8 + lt;
            end
        end
        put_tags(b, m, m);
        wr32(b + 4, shadow_head);
        wr32(b + 8, 0);
        if (shadow_head != 0) wr32(shadow_head + 8, b);
        shadow_head = b;
        return 1'b1;
    endfunction

    // Applies one request to the shadow heap and queues it with its expected answer.
    task automatic issue(logic [1:0] op, logic [15:0] sz, logic [15:0] addr);
        heap_req_t  rq;
        heap_resp_t rs;
        int unsigned got;
        rq = '{op: op, req_size: sz, addr: addr};
        rs = '{result_addr: 16'd0, status: 1'b1};
        case (op)
            OP_ALLOC: begin
                got = first_fit_alloc(sz);
                rs.result_addr = got[15:0];
                rs.status = (got == 0);
                if (got != 0) live_addrs.push_back(got);
            end
            OP_FREE: begin
                rs.status = !release_block(addr);
                if (!rs.status) begin
                    foreach (live_addrs[i])
                        if (live_addrs[i] == addr) begin
                            live_addrs.delete(i);
                            break;
                        end
                end
            end
            OP_CHECK: rs.status = !block_in_use(addr);
            default: ;
        endcase
        request_q.push_back(rq);
        response_q.push_back(rs);
    endtask

    task automatic drain_and_resize(logic [16:0] bytes);
        while (request_q.size() != 0 || response_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_data <= bytes;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        heap_reinit(bytes);
    endtask

    function automatic logic [15:0] pick_live();
        return 16'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
    endfunction

    task automatic random_mix(int unsigned count);
        int unsigned sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                issue(OP_ALLOC, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                            : 16'($urandom_range(0, 160)), '0);
            end else if (sel < 80) begin
                if (live_addrs.size() != 0 && $urandom_range(0, 9) < 8)
                    issue(OP_FREE, 16'($urandom), pick_live());
                else
                    issue(OP_FREE, 16'($urandom), 16'($urandom));
            end else if (sel < 96) begin
                if (live_addrs.size() != 0 && $urandom_range(0, 1) == 0)
                    issue(OP_CHECK, 16'($urandom), pick_live());
                else
                    issue(OP_CHECK, 16'($urandom), 16'($urandom_range(0, 65535)));
            end else begin
                issue(OP_NONE, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Sampled acceptance of the request held on the bus.
    always @(posedge i_clk) begin
        req_taken <= i_s_tvalid && o_s_tready;
    end

    // Request driver.
    always @(negedge i_clk) begin
        heap_req_t rq;
        if (i_rst_n && (!i_s_tvalid || req_taken)) begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                rq = request_q.pop_front();
                i_s_tdata <= {rq.addr, rq.req_size};
                i_s_tuser <= rq.op;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_cycles = 400;
        end
        if (hold_cycles != 0) begin
            hold_cycles = hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        heap_resp_t want;
        if (o_m_tvalid && i_m_tready) begin
            if (response_q.size() == 0) begin
                $error("result item with nothing expected: %h", o_m_tdata);
                err_count++;
            end else begin
                want = response_q.pop_front();
                if (o_m_tdata[15:0] !== want.result_addr) begin
                    $error("result_addr: expected %h, got %h", want.result_addr,
                           o_m_tdata[15:0]);
                    err_count++;
                end
                if (o_m_tdata[16] !== want.status) begin
                    $error("status: expected %b, got %b", want.status, o_m_tdata[16]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        logic [16:0] sizes[6];
        logic [15:0] a0, a1, a2;
        sizes = '{17'd2000, 17'd16, 17'd600, 17'h1FFFF, 17'd24, 17'd8190};
        heap_reinit(17'd65536);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the default heap.
        issue(OP_ALLOC, 16'd0, '0);
        a0 = 16'(live_addrs[0]);
        issue(OP_ALLOC, 16'd1, '0);
        issue(OP_ALLOC, 16'd7, '0);
        a1 = 16'(live_addrs[2]);
        issue(OP_ALLOC, 16'd9, '0);
        a2 = 16'(live_addrs[3]);
        issue(OP_ALLOC, 16'hFFFF, '0);
        issue(OP_CHECK, '0, a0);
        issue(OP_FREE, '0, 16'd0);
        issue(OP_FREE, '0, a1 + 16'd1);
        issue(OP_FREE, '0, 16'hFFFF);
        issue(OP_FREE, '0, a1);
        issue(OP_FREE, '0, a1);
        issue(OP_CHECK, '0, a1);
        issue(OP_FREE, '0, a0);
        issue(OP_FREE, '0, a2);
        issue(OP_NONE, 16'hFFFF, 16'hFFFF);
        issue(OP_CHECK, 16'hFFFF, 16'hFFFE);
        issue(OP_ALLOC, 16'd65500, '0);
        issue(OP_ALLOC, 16'd8, '0);
        issue(OP_FREE, '0, 16'(live_addrs[0]));
        issue(OP_ALLOC, 16'd65520, '0);
        issue(OP_ALLOC, 16'd2, '0);
        issue(OP_FREE, '0, 16'd4);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_resize(sizes[ph]);
            if (ph == 2 || ph == 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 25;
            end else if (ph >= 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 4) hold_req = 1'b1;
            random_mix((sizes[ph] < 24) ? 30 : 150);
        end

        while (request_q.size() != 0 || response_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("boundary_tag_heap_allocator: match");
        end else begin
            $display("boundary_tag_heap_allocator: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #50ms;
        $display("boundary_tag_heap_allocator: mismatch");
        $finish;
    end

endmodule

>>> boundary_tag_heap_allocator.f
+incdir+rtl/core
rtl/core/bth_pkg.sv
rtl/core/bth_ram.sv
rtl/core/boundary_tag_heap_allocator.sv
rtl/core/bth_chk.sv
test/testbench.sv
